// ===== hdl/bspq_pkg.sv =====
package bspq_pkg;

  localparam int DEPTH     = 16;
  localparam int TAG_BITS  = 32;
  localparam int PRIO_BITS = 8;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int OCC_W     = 5;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 3;

  localparam logic [1:0] ACT_ENQ  = 2'd0;
  localparam logic [1:0] ACT_DEQ  = 2'd1;
  localparam logic [1:0] ACT_PEEK = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [TAG_BITS-1:0]  tag;
    logic [PRIO_BITS-1:0] prio;
  } entry_t;

  // Per-cell control from the queue controller.
  typedef struct packed {
    logic enq;       // insert the new entry this cycle
    logic deq;       // every cell takes its right-hand neighbour
    logic occupied;  // this cell holds an entry
    logic is_slot;   // this cell is the first free one
  } cell_ctrl_t;

endpackage

// ===== hdl/bspq_cell.sv =====
module bspq_cell
  import bspq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     new_entry,
  input  entry_t     left_entry,
  input  logic       left_move,
  input  entry_t     right_entry,
  output entry_t     entry,
  output logic       move
);

  entry_t entry_r;
  entry_t entry_nxt;

  // A held entry with a strictly larger priority moves back by one place, so entries of
  // equal priority stay ahead of the newcomer.
  assign move = ctrl.is_slot || (ctrl.occupied && (entry_r.prio > new_entry.prio));

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.deq) begin
      entry_nxt = right_entry;
    end else if (ctrl.enq && move) begin
      entry_nxt = left_move ? left_entry : new_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// ===== hdl/bounded_stable_priority_queue.sv =====
// Bounded priority queue of DEPTH tagged entries held in a row of cells, front in cell
// zero. The lowest priority value leaves first and entries of equal priority leave in
// arrival order. Each request (enqueue, dequeue or peek, action 3 ignored) yields exactly
// one result carrying a status code, the occupancy after the request and, for a dequeue or
// peek on a non-empty queue, the front entry. All cells compare their priority against
// the new entry in parallel and shift by at most one place, so a new request is taken
// every cycle while the result register is free or being emptied.
module bounded_stable_priority_queue
  import bspq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // entry_tag[31:0], entry_priority[39:32]
  input  logic [1:0]            in_tuser,   // action[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // out_tag[31:0], out_priority[39:32],
                                            // occupancy[44:40], is_full[45],
                                            // is_empty[46], zero[47]
  output logic [OUT_USER_W-1:0] out_tuser   // out_valid[0], status[2:1]
);

  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [OUT_USER_W-1:0] out_tuser_r;

  logic       accept;
  logic       full;
  logic       empty;
  logic       do_enq;
  logic       do_deq;
  logic [1:0] action;
  logic [1:0] status;
  logic       res_valid;
  entry_t     new_entry;
  entry_t     front;

  entry_t     cell_entry [DEPTH];
  logic       cell_move  [DEPTH];
  cell_ctrl_t cell_ctrl  [DEPTH];

  assign in_tready     = !out_tvalid_r || out_tready;
  assign accept        = in_tvalid && in_tready;
  assign action        = in_tuser;
  assign new_entry.tag  = in_tdata[TAG_BITS-1:0];
  assign new_entry.prio = in_tdata[TAG_BITS +: PRIO_BITS];
  assign full          = (count_r == CNT_W'(DEPTH));
  assign empty         = (count_r == '0);
  assign front         = cell_entry[0];

  always_comb begin
    do_enq    = 1'b0;
    do_deq    = 1'b0;
    status    = ST_DONE;
    res_valid = 1'b0;
    unique case (action)
      ACT_ENQ: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          do_enq = accept;
        end
      end
      ACT_DEQ: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          do_deq    = accept;
          res_valid = 1'b1;
        end
      end
      ACT_PEEK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          res_valid = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (do_enq) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_deq) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_entry;
    logic   left_move;
    entry_t right_entry;

    assign cell_ctrl[i].enq      = do_enq;
    assign cell_ctrl[i].deq      = do_deq;
    assign cell_ctrl[i].occupied = (CNT_W'(i) < count_r);
    assign cell_ctrl[i].is_slot  = (CNT_W'(i) == count_r);

    if (i == 0) begin : g_head
      assign left_entry = new_entry;
      assign left_move  = 1'b0;
    end else begin : g_body
      assign left_entry = cell_entry[i-1];
      assign left_move  = cell_move[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    bspq_cell u_cell (
      .clk         (clk),
      .ctrl        (cell_ctrl[i]),
      .new_entry   (new_entry),
      .left_entry  (left_entry),
      .left_move   (left_move),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .move        (cell_move[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_tdata_r <= {1'b0,
                      (count_nxt == '0),
                      (count_nxt == CNT_W'(DEPTH)),
                      OCC_W'(count_nxt),
                      res_valid ? front.prio : '0,
                      res_valid ? front.tag  : '0};
      out_tuser_r <= {status, res_valid};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond capacity");

  a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && action == ACT_ENQ && !full) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("enqueue did not add an entry");

  a_front_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> (cell_entry[0].prio <= cell_entry[1].prio))
    else $error("front entries out of priority order");

  a_entry_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tuser_r[0]) |-> (out_tuser_r[2:1] == ST_DONE))
    else $error("result carries an entry with a failure status");

endmodule
